[hdl/rrw_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrw_pkg
// Shared types and constants for the receive reorder window.
// ---------------------------------------------------------------------------
package rrw_pkg;

	localparam int WINDOW_SIZE = 64;
	localparam int SEQ_BITS    = 16;
	localparam int HANDLE_BITS = 16;
	localparam int IDX_BITS    = $clog2(WINDOW_SIZE);
	localparam int RANGE_BITS  = 7;
	localparam int COUNT_BITS  = 7;
	localparam int MASK_BITS   = 64;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_POP = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_ALREADY  = 3'd2,
		ST_NO_DATA  = 3'd3,
		ST_MISMATCH = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] seq_in;
		logic [15:0] payload_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] payload_out;
		logic [63:0] sync_mask;
		logic [15:0] base_seq;
		logic [6:0]  msg_count;
	} rsp_t;

endpackage

[hdl/receive_reorder_window.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// receive_reorder_window
// Each accepted item and its memory read data are held in stage-1 registers;
// the result is registered in the output register once that register is free.
// A new item is taken only after the last one has done the read-modify-write
// of the slot tag and payload memories (read on accept, update in the execute
// state); a stalled result holds the update, and so the input, until it is taken.
// Reset: asynchronous; base, count, occupancy and tag-written bits clear at
// once. Unwritten tags read as their reset value, so no clearing pass.
// ---------------------------------------------------------------------------
module receive_reorder_window
	import rrw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [RANGE_BITS-1:0] cfg_data
);

	// storage
	logic [SEQ_BITS-1:0]    tag_mem [WINDOW_SIZE];
	logic [HANDLE_BITS-1:0] pay_mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0] tag_vld_q;
	logic [WINDOW_SIZE-1:0] full_q;
	logic [WINDOW_SIZE-1:0] occ_q;
	logic [SEQ_BITS-1:0]    base_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [RANGE_BITS-1:0]  range_q;

	state_t state_q, state_n;

	// stage 1: item and read data
	logic                   mode_s1;
	logic [SEQ_BITS-1:0]    seq_s1;
	logic [HANDLE_BITS-1:0] pay_in_s1;
	logic [IDX_BITS-1:0]    idx_s1;
	logic [SEQ_BITS-1:0]    tag_rd_s1;
	logic [HANDLE_BITS-1:0] pay_rd_s1;
	logic                   vld_rd_s1;

	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	logic                   req_fire;
	logic                   exec_fire;
	logic [IDX_BITS-1:0]    rd_idx;
	logic [SEQ_BITS-1:0]    seq_in_w;

	// update signals
	logic [SEQ_BITS-1:0]    tag_cur;
	logic [SEQ_BITS-1:0]    diff;
	logic [SEQ_BITS-1:0]    tag_diff;
	logic [SEQ_BITS-1:0]    expect_tag;
	logic signed [SEQ_BITS:0] diff_x;
	logic signed [SEQ_BITS:0] range_x;
	status_t                status_w;
	logic [HANDLE_BITS-1:0] pay_out_w;
	logic                   tag_we;
	logic [WINDOW_SIZE-1:0] full_n;
	logic [WINDOW_SIZE-1:0] occ_n;
	logic [SEQ_BITS-1:0]    base_n;
	logic [COUNT_BITS-1:0]  count_n;
	logic [WINDOW_SIZE-1:0] slot_bit;
	logic [2*WINDOW_SIZE-1:0] occ_dbl;
	logic [WINDOW_SIZE-1:0] rot;
	logic [WINDOW_SIZE-1:0] keep;

	assign seq_in_w  = req.seq_in[SEQ_BITS-1:0];
	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rd_idx    = (req.mode == MODE_POP) ? base_q[IDX_BITS-1:0]
	                                          : seq_in_w[IDX_BITS-1:0];
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec_fire) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// memory read on accept, write on update
	always_ff @(posedge clk) begin
		if (req_fire) begin
			tag_rd_s1 <= tag_mem[rd_idx];
			pay_rd_s1 <= pay_mem[rd_idx];
		end
		if (tag_we) begin
			tag_mem[idx_s1] <= seq_s1;
			pay_mem[idx_s1] <= pay_in_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_s1   <= req.mode;
			seq_s1    <= seq_in_w;
			pay_in_s1 <= req.payload_in[HANDLE_BITS-1:0];
			idx_s1    <= rd_idx;
			vld_rd_s1 <= tag_vld_q[rd_idx];
		end
	end

	// update logic
	always_comb begin
		// a never-written slot holds (index - window) mod 2^SEQ_BITS
		tag_cur    = vld_rd_s1 ? tag_rd_s1
		                       : SEQ_BITS'(idx_s1) - SEQ_BITS'(WINDOW_SIZE);
		diff       = seq_s1 - base_q;
		diff_x     = {diff[SEQ_BITS-1], diff};
		range_x    = {{(SEQ_BITS+1-RANGE_BITS){1'b0}}, range_q};
		expect_tag = seq_s1 - SEQ_BITS'(WINDOW_SIZE);
		tag_diff   = tag_cur - seq_s1;
		slot_bit   = {{(WINDOW_SIZE-1){1'b0}}, 1'b1} << idx_s1;

		status_w  = ST_OK;
		pay_out_w = '0;
		tag_we    = 1'b0;
		full_n    = full_q;
		occ_n     = occ_q;
		base_n    = base_q;
		count_n   = count_q;

		if (mode_s1 == MODE_ADD) begin
			if (diff_x >= range_x) begin
				status_w = ST_OVERFLOW;
			end else if (diff_x < 0) begin
				status_w = ST_ALREADY;
			end else if (tag_cur != expect_tag) begin
				// slot taken: older or equal tag means already seen
				status_w = (tag_diff[SEQ_BITS-1] || tag_diff == '0) ? ST_ALREADY
				                                                   : ST_OVERFLOW;
			end else begin
				tag_we = 1'b1;
				full_n = full_q | slot_bit;
				occ_n  = occ_q | slot_bit;
				if (count_q != {COUNT_BITS{1'b1}}) begin
					count_n = count_q + 1'b1;
				end
			end
		end else begin
			if ((full_q & slot_bit) == '0) begin
				status_w = ST_NO_DATA;
			end else begin
				full_n = full_q & ~slot_bit;
				if (tag_cur != base_q) begin
					status_w = ST_MISMATCH;
				end else begin
					pay_out_w = pay_rd_s1;
					base_n    = base_q + 1'b1;
					occ_n     = occ_q & ~slot_bit;
					if (count_q != '0) begin
						count_n = count_q - 1'b1;
					end
				end
			end
		end

		if (!exec_fire) begin
			tag_we = 1'b0;
		end

		// mask relative to the new base, limited to accept_range
		occ_dbl = {occ_n, occ_n};
		rot     = WINDOW_SIZE'(occ_dbl >> base_n[IDX_BITS-1:0]);
		for (int k = 0; k < WINDOW_SIZE; k++) begin
			keep[k] = (RANGE_BITS'(k) < range_q);
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_vld_q <= '0;
			full_q    <= '0;
			occ_q     <= '0;
			base_q    <= '0;
			count_q   <= '0;
			range_q   <= RANGE_BITS'(WINDOW_SIZE);
		end else begin
			if (cfg_valid && cfg_ready) begin
				range_q <= cfg_data;
			end
			if (exec_fire) begin
				full_q  <= full_n;
				occ_q   <= occ_n;
				base_q  <= base_n;
				count_q <= count_n;
				if (tag_we) begin
					tag_vld_q <= tag_vld_q | slot_bit;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q.status      <= status_w;
			rsp_q.payload_out <= 16'(pay_out_w);
			rsp_q.sync_mask   <= MASK_BITS'(rot & keep);
			rsp_q.base_seq    <= 16'(base_n);
			rsp_q.msg_count   <= count_n;
		end
	end

	// checks
	a_full_in_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q & ~occ_q) == '0)
		else $error("data-present bit set outside occupancy");

	a_hold_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && rsp_valid_q && rsp_stall) |=> state_q == S_EXEC)
		else $error("update left while output register blocked");

	a_base_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(base_q) |-> $past(exec_fire) && $past(mode_s1) == MODE_POP)
		else $error("base moved without a pop");

	a_rsp_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_EXEC)
		else $error("result without an update cycle");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives add and pop items into receive_reorder_window under random
// valid/stall gaps and a few accept_range settings, predicts every result
// from a cycle-free model of the window and checks each result in order.
// ---------------------------------------------------------------------------
module testbench
	import rrw_pkg::*;
();

	class window_scoreboard;
		logic [RANGE_BITS-1:0]  accept_lim;
		logic [SEQ_BITS-1:0]    slot_tags [WINDOW_SIZE];
		logic [HANDLE_BITS-1:0] slot_handles [WINDOW_SIZE];
		logic [WINDOW_SIZE-1:0] full_bits;
		logic [WINDOW_SIZE-1:0] occ_bits;
		logic [SEQ_BITS-1:0]    base_sq;
		logic [COUNT_BITS-1:0]  held;
		rsp_t                   expected_rsp [$];
		int                     mismatches;

		function new();
			accept_lim = 7'd64;
			for (int i = 0; i < WINDOW_SIZE; i++) begin
				slot_tags[i] = 16'(i - WINDOW_SIZE);
				slot_handles[i] = '0;
			end
			full_bits = '0;
			occ_bits = '0;
			base_sq = '0;
			held = '0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// wrapping difference a - b read as a signed sequence offset
		function int seq_delta(logic [SEQ_BITS-1:0] a, logic [SEQ_BITS-1:0] b);
			logic [SEQ_BITS-1:0] d;
			d = a - b;
			return int'($signed(d));
		endfunction

		function logic [MASK_BITS-1:0] window_mask();
			logic [MASK_BITS-1:0] m;
			logic [IDX_BITS-1:0] s;
			m = '0;
			for (int k = 0; k < WINDOW_SIZE && k < int'(accept_lim); k++) begin
				s = base_sq[IDX_BITS-1:0] + IDX_BITS'(k);
				m[k] = occ_bits[s];
			end
			return m;
		endfunction

		function rsp_t predict_window(req_t it);
			rsp_t r;
			int delta;
			logic [IDX_BITS-1:0] idx;
			r = '0;
			r.status = ST_OK;
			if (it.mode == MODE_ADD) begin
				delta = seq_delta(it.seq_in, base_sq);
				if (delta >= int'(accept_lim)) begin
					r.status = ST_OVERFLOW;
				end else if (delta < 0) begin
					r.status = ST_ALREADY;
				end else begin
					idx = it.seq_in[IDX_BITS-1:0];
					if (slot_tags[idx] != it.seq_in - 16'(WINDOW_SIZE)) begin
						r.status = (seq_delta(slot_tags[idx], it.seq_in) <= 0) ?
							ST_ALREADY : ST_OVERFLOW;
					end else begin
						// may replace data still held when the range exceeds the window
						slot_tags[idx] = it.seq_in;
						slot_handles[idx] = it.payload_in;
						full_bits[idx] = 1'b1;
						occ_bits[idx] = 1'b1;
						if (held != 7'd127)
							held = held + 7'd1;
					end
				end
			end else begin
				idx = base_sq[IDX_BITS-1:0];
				if (!full_bits[idx]) begin
					r.status = ST_NO_DATA;
				end else begin
					full_bits[idx] = 1'b0;
					if (slot_tags[idx] != base_sq) begin
						r.status = ST_MISMATCH;
					end else begin
						r.payload_out = slot_handles[idx];
						base_sq = base_sq + 16'd1;
						if (held != 7'd0)
							held = held - 7'd1;
						occ_bits[idx] = 1'b0;
					end
				end
			end
			r.sync_mask = window_mask();
			r.base_seq = base_sq;
			r.msg_count = held;
			return r;
		endfunction

		function void note_item(req_t it);
			expected_rsp.push_back(predict_window(it));
		endfunction

		function void check_item(rsp_t got);
			rsp_t want;
			bit bad;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with no item pending: status %0d base %h count %0d",
						got.status, got.base_seq, got.msg_count);
				return;
			end
			want = expected_rsp.pop_front();
			bad = (got.status !== want.status) || (got.payload_out !== want.payload_out) ||
				(got.sync_mask !== want.sync_mask) || (got.base_seq !== want.base_seq) ||
				(got.msg_count !== want.msg_count);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp/act: status %0d/%0d payload %h/%h base %h/%h count %0d/%0d",
						want.status, got.status, want.payload_out, got.payload_out,
						want.base_seq, got.base_seq, want.msg_count, got.msg_count);
					$display("  mask exp %h act %h", want.sync_mask, got.sync_mask);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [RANGE_BITS-1:0] cfg_data = '0;

	logic hold_rsp = 1'b0;
	int   send_idle_pct = 21;
	int   recv_idle_pct = 67;
	int   drain_wait;

	window_scoreboard sb;

	receive_reorder_window DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_item(rsp);
		rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
	end

	// called right after a rising edge; returns at the edge the item is taken
	task automatic send_item(input req_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_item(it);
	endtask

	task automatic send_add(input logic [15:0] seq, input logic [15:0] handle);
		req_t it;
		it.mode = MODE_ADD;
		it.seq_in = seq;
		it.payload_in = handle;
		send_item(it);
	endtask

	task automatic send_pop();
		req_t it;
		it.mode = MODE_POP;
		it.seq_in = 16'($urandom);
		it.payload_in = 16'($urandom);
		send_item(it);
	endtask

	// mostly adds near the base so the window fills and drains, plus noise
	task automatic run_random(input int n);
		req_t it;
		int roll;
		for (int i = 0; i < n; i++) begin
			it.mode = MODE_ADD;
			it.seq_in = 16'($urandom);
			it.payload_in = 16'($urandom);
			roll = $urandom_range(99);
			if (roll < 38)
				it.mode = MODE_POP;
			else if (roll < 48)
				;
			else if (roll < 70)
				it.seq_in = sb.base_sq + 16'($urandom_range(3));
			else
				it.seq_in = sb.base_sq + 16'($urandom_range(int'(sb.accept_lim) + 3)) -
					16'($urandom_range(2));
			send_item(it);
		end
	endtask

	task automatic drain_window();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_range(input logic [RANGE_BITS-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.accept_lim = v;
	endtask

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, range edges, negative offsets, duplicate, slot wrap
		send_pop();
		send_add(16'h0000, 16'hFFFF);
		send_add(16'h0000, 16'h1111);
		send_add(16'h003F, 16'h0000);
		send_add(16'h0040, 16'h2222);
		send_add(16'hFFFF, 16'h3333);
		send_add(16'h8000, 16'h4444);
		send_add(16'h7FFF, 16'h5555);
		send_pop();
		send_pop();
		send_add(16'h0001, 16'hA5A5);
		send_pop();
		send_add(16'h0000, 16'h5A5A);
		send_add(16'h0041, 16'h6666);
		send_add(16'h0002, 16'h7777);
		send_pop();
		send_pop();
		drain_window();

		write_range(7'd64);
		fork
			begin
				hold_rsp <= 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp <= 1'b0;
			end
			run_random(200);
		join
		drain_window();

		write_range(7'd1);
		run_random(60);
		drain_window();

		send_idle_pct = 67;
		recv_idle_pct = 21;
		write_range(7'($urandom_range(2, 63)));
		run_random(150);
		drain_window();

		write_range(7'd0);
		run_random(40);
		drain_window();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_range(7'd64);
		run_random(75);
		drain_window();
		run_random(75);
		drain_window();

		// range past the window: overwrite of held data, then a tag mismatch on pop
		write_range(7'd127);
		run_random(100);
		if (sb.slot_tags[sb.base_sq[IDX_BITS-1:0]] == sb.base_sq - 16'(WINDOW_SIZE))
			send_add(sb.base_sq, 16'h1234);
		send_add(sb.base_sq + 16'(WINDOW_SIZE), 16'h4321);
		send_pop();
		send_pop();
		send_add(sb.base_sq, 16'h0F0F);
		req_valid <= 1'b0;

		drain_wait = 0;
		while (sb.pending() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
